FILE: rtl/core/prc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, types and helpers for the point rotation datapath.
// ----------------------------------------------------------------------------
package prc_pkg;

    // datapath fraction bits and number of micro-rotations
    localparam int FRACTION_BITS   = 16;
    localparam int ROTATION_STAGES = 16;

    // arctangent table entries available
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_N     = (ROTATION_STAGES < ATAN_ENTRIES) ?
                                  ROTATION_STAGES : ATAN_ENTRIES;

    // field widths of the channel words
    localparam int COORD_W = 17;
    localparam int ANGLE_W = 18;
    localparam int RES_W   = 18;

    // internal widths
    localparam int DX_W      = COORD_W + 1;
    localparam int GAIN_W    = 31;
    localparam int PROD_W    = DX_W + GAIN_W;
    localparam int DATA_W    = FRACTION_BITS + 4;
    localparam int Z_W       = 34;
    localparam int SCALE_SH  = 46 - FRACTION_BITS;
    localparam int OUT_SHIFT = FRACTION_BITS - 16;
    localparam int WIDE_W    = DATA_W + 20;

    // centre of the unit square in Q.16
    localparam int HALF_Q16 = 32768;

    // cordic gain correction 0.607252935 in Q0.30
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(652032874);

    // output saturation bounds
    localparam logic signed [WIDE_W-1:0] OUT_MIN = -WIDE_W'(131072);
    localparam logic signed [WIDE_W-1:0] OUT_MAX = WIDE_W'(131071);

    // atan(2^-i) with 2^32 per turn
    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // whole quarter turns taken out before the micro-rotations
    typedef enum logic [1:0] {
        QTR_ZERO,
        QTR_ONE,
        QTR_TWO,
        QTR_THREE
    } quarter_t;

    // vector moving down the rotation pipeline
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [Z_W-1:0]    z;
    } prc_vec_t;

    // back to Q.16, add the centre, saturate to the result width
    function automatic logic [RES_W-1:0] to_output(input logic signed [DATA_W-1:0] v);
        logic signed [WIDE_W-1:0] w;
        logic signed [WIDE_W-1:0] r;
        if (OUT_SHIFT > 0)
        begin
            w = (WIDE_W'(v) + (WIDE_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        end
        else
        begin
            w = WIDE_W'(v) <<< (-OUT_SHIFT);
        end
        r = w + WIDE_W'(HALF_Q16);
        if (r < OUT_MIN)
        begin
            r = OUT_MIN;
        end
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
        end
        return r[RES_W-1:0];
    endfunction

endpackage

FILE: rtl/core/prc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_in_if
// Input channel: one point and one rotation angle per word.
// ----------------------------------------------------------------------------
interface prc_in_if
    import prc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [COORD_W-1:0]        point_x;
    logic [COORD_W-1:0]        point_y;
    logic signed [ANGLE_W-1:0] turn_angle;

    modport source (output valid, output point_x, output point_y, output turn_angle,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input turn_angle,
                    output ready);
endinterface

FILE: rtl/core/prc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_out_if
// Output channel: one rotated point per word.
// ----------------------------------------------------------------------------
interface prc_out_if
    import prc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] rotated_x;
    logic signed [RES_W-1:0] rotated_y;

    modport source (output valid, output rotated_x, output rotated_y, input ready);
    modport sink   (input valid, input rotated_x, input rotated_y, output ready);
endinterface

FILE: rtl/core/prc_prescale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_prescale
// Two stages: centre offset times gain correction, then rounding and the
// exact quarter-turn rotation. Also splits the angle into quarter and rest.
// ----------------------------------------------------------------------------
module prc_prescale
    import prc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [COORD_W-1:0]        point_x,
    input  logic [COORD_W-1:0]        point_y,
    input  logic signed [ANGLE_W-1:0] turn_angle,
    output logic                      out_valid,
    output prc_vec_t                  out_vec
);

    logic signed [DX_W-1:0]   dx;
    logic signed [DX_W-1:0]   dy;
    logic [15:0]              a_plus;
    logic [15:0]              rest;
    quarter_t                 q_next;

    logic signed [PROD_W-1:0] px_reg, px_next;
    logic signed [PROD_W-1:0] py_reg, py_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    quarter_t                 q_reg;
    logic                     v1_reg;

    logic signed [PROD_W-1:0] rx_wide;
    logic signed [PROD_W-1:0] ry_wide;
    logic signed [DATA_W-1:0] rx;
    logic signed [DATA_W-1:0] ry;
    prc_vec_t                 vec_reg, vec_next;
    logic                     v2_reg;

    // offset from the centre and gain-corrected products
    assign dx      = $signed({1'b0, point_x}) - DX_W'(HALF_Q16);
    assign dy      = $signed({1'b0, point_y}) - DX_W'(HALF_Q16);
    assign px_next = PROD_W'(dx) * PROD_W'(GAIN_Q30);
    assign py_next = PROD_W'(dy) * PROD_W'(GAIN_Q30);

    // nearest quarter turn and the residual angle in 2^32 per turn
    assign a_plus = turn_angle[15:0] + 16'd8192;
    assign q_next = quarter_t'(a_plus[15:14]);
    assign rest   = turn_angle[15:0] - {a_plus[15:14], 14'd0};
    assign z_next = Z_W'($signed({rest, 16'd0}));

    // stage one valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    // stage one payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            z_reg  <= z_next;
            q_reg  <= q_next;
        end
    end

    // round products back to the datapath scale
    assign rx_wide = (px_reg + (PROD_W'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
    assign ry_wide = (py_reg + (PROD_W'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
    assign rx      = rx_wide[DATA_W-1:0];
    assign ry      = ry_wide[DATA_W-1:0];

    // exact quarter-turn rotation
    always_comb
    begin
        vec_next.z = z_reg;
        case (q_reg)
            QTR_ZERO:
            begin
                vec_next.x = rx;
                vec_next.y = ry;
            end
            QTR_ONE:
            begin
                vec_next.x = -ry;
                vec_next.y = rx;
            end
            QTR_TWO:
            begin
                vec_next.x = -rx;
                vec_next.y = -ry;
            end
            QTR_THREE:
            begin
                vec_next.x = ry;
                vec_next.y = -rx;
            end
            default:
            begin
                vec_next.x = rx;
                vec_next.y = ry;
            end
        endcase
    end

    // stage two valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg <= vec_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_vec   = vec_reg;

endmodule

FILE: rtl/core/prc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_cordic
// Unrolled CORDIC rotation: one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module prc_cordic
    import prc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  prc_vec_t                 in_vec,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_x,
    output logic signed [DATA_W-1:0] out_y
);

    logic     v_reg   [CORDIC_N];
    prc_vec_t vec_reg [CORDIC_N];

    genvar k;
    generate
        for (k = 0; k < CORDIC_N; k++)
        begin : g_stage
            prc_vec_t                 src;
            logic                     src_v;
            logic signed [DATA_W-1:0] xs;
            logic signed [DATA_W-1:0] ys;
            prc_vec_t                 vec_next;

            if (k == 0)
            begin : g_first
                assign src   = in_vec;
                assign src_v = in_valid;
            end
            else
            begin : g_rest
                assign src   = vec_reg[k-1];
                assign src_v = v_reg[k-1];
            end

            // micro-rotation by atan(2^-k), direction from the angle sign
            assign xs = src.x >>> k;
            assign ys = src.y >>> k;
            always_comb
            begin
                if (!src.z[Z_W-1])
                begin
                    vec_next.x = src.x - ys;
                    vec_next.y = src.y + xs;
                    vec_next.z = src.z - Z_W'(ATAN_TURNS[k]);
                end
                else
                begin
                    vec_next.x = src.x + ys;
                    vec_next.y = src.y - xs;
                    vec_next.z = src.z + Z_W'(ATAN_TURNS[k]);
                end
            end

            // stage valid
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= src_v;
                end
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    vec_reg[k] <= vec_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[CORDIC_N-1];
    assign out_x     = vec_reg[CORDIC_N-1].x;
    assign out_y     = vec_reg[CORDIC_N-1].y;

endmodule

FILE: rtl/core/point_rotate_about_center.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_about_center
// Rotates a point about (0.5, 0.5) by an angle in turns using an unrolled
// CORDIC pipeline, with an output register and a skid word.
// ----------------------------------------------------------------------------
// channel  dir  handshake     word
// pt_in    in   valid/ready   point_x, point_y, turn_angle
// pt_out   out  valid/ready   rotated_x, rotated_y
//
// a word is accepted every cycle while the skid word is empty; the stages are
// two prescale stages, one per micro-rotation, one output register.
// the pipeline moves as one unit; it freezes only while the skid word is full.
// reset clears valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module point_rotate_about_center
    import prc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    prc_in_if.sink       pt_in,
    prc_out_if.source    pt_out
);

    logic                     en;
    logic                     pre_valid;
    prc_vec_t                 pre_vec;
    logic                     cor_valid;
    logic signed [DATA_W-1:0] cor_x;
    logic signed [DATA_W-1:0] cor_y;
    logic [RES_W-1:0]         res_x;
    logic [RES_W-1:0]         res_y;

    logic                     out_valid_reg;
    logic [RES_W-1:0]         out_x_reg;
    logic [RES_W-1:0]         out_y_reg;
    logic                     skid_valid_reg;
    logic [RES_W-1:0]         skid_x_reg;
    logic [RES_W-1:0]         skid_y_reg;

    // pipeline advances unless the skid word is occupied
    assign en          = !skid_valid_reg;
    assign pt_in.ready = en;

    prc_prescale u_prescale (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (pt_in.valid),
        .point_x    (pt_in.point_x),
        .point_y    (pt_in.point_y),
        .turn_angle (pt_in.turn_angle),
        .out_valid  (pre_valid),
        .out_vec    (pre_vec)
    );

    prc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_vec    (pre_vec),
        .out_valid (cor_valid),
        .out_x     (cor_x),
        .out_y     (cor_y)
    );

    // add centre back and saturate
    assign res_x = to_output(cor_x);
    assign res_y = to_output(cor_y);

    // output register and skid word control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg)
        begin
            if (pt_out.ready || !out_valid_reg)
            begin
                out_valid_reg <= cor_valid;
            end
            else if (cor_valid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pt_out.ready)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
    end

    // output register and skid word payload
    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg)
        begin
            if (pt_out.ready || !out_valid_reg)
            begin
                out_x_reg <= res_x;
                out_y_reg <= res_y;
            end
            else
            begin
                skid_x_reg <= res_x;
                skid_y_reg <= res_y;
            end
        end
        else if (pt_out.ready)
        begin
            out_x_reg <= skid_x_reg;
            out_y_reg <= skid_y_reg;
        end
    end

    assign pt_out.valid     = out_valid_reg;
    assign pt_out.rotated_x = $signed(out_x_reg);
    assign pt_out.rotated_y = $signed(out_y_reg);

`ifndef ASSERT_OFF
    // a parked skid word always has an output word ahead of it
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    // the skid word fills only when the output is stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !pt_out.ready && cor_valid))
        else $error("skid word filled while the output was free");

    // a waiting skid word keeps its contents
    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !pt_out.ready |=>
            skid_valid_reg && $stable(skid_x_reg) && $stable(skid_y_reg))
        else $error("skid word changed while stalled");
`endif

endmodule

FILE: test/point_rotate_about_center_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_about_center_tb
// Self-checking bench for the CORDIC point rotation about (0.5, 0.5). The
// bench predicts every rotated point in fixed point, keeps the predictions in
// order and compares them with each word that leaves the block. It covers a
// directed set of corner points and angles, then random points under random
// idling on both channels, a long receiver hold-off that fills the pipeline,
// a full drain and a final stretch with both sides always ready.
// ----------------------------------------------------------------------------
module point_rotate_about_center_tb
    import prc_pkg::*;
;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_ITEMS   = 50;
    localparam int STEADY_ITEMS = 50;
    localparam int LONG_HOLD    = 100;
    localparam int DRAIN_CYCLES = 3 * (CORDIC_N + 3);
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    // what the receiver does in each part of the run
    typedef enum logic [1:0] {
        PH_MIXED,
        PH_BACKPRESSURE,
        PH_STEADY
    } tb_phase_t;

    // one rotated point as it should come out
    typedef struct {
        logic signed [RES_W-1:0] rx;
        logic signed [RES_W-1:0] ry;
    } rot_point_t;

    // predicts rotated points and checks them in arrival order
    class point_tracker;
        rot_point_t due_q[$];
        int         mismatches;

        // back to Q.16, add the centre, saturate, keep the result bits
        function logic signed [RES_W-1:0] fold_output(longint v);
            longint r;
            if (OUT_SHIFT > 0)
            begin
                r = (v + (longint'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
            end
            else
            begin
                r = v <<< (-OUT_SHIFT);
            end
            r = r + HALF_Q16;
            if (r < -131072)
            begin
                r = -131072;
            end
            if (r > 131071)
            begin
                r = 131071;
            end
            return r[RES_W-1:0];
        endfunction

        // gain-corrected offset, exact quarter turns, then micro-rotations
        function rot_point_t rotate_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                          logic signed [ANGLE_W-1:0] ang);
            longint      ox;
            longint      oy;
            longint      vx;
            longint      vy;
            longint      tmp;
            longint      xs;
            longint      ys;
            longint      z;
            logic [15:0] frac;
            logic [1:0]  qbits;
            logic [15:0] resid;
            quarter_t    quad;
            rot_point_t  res;
            ox    = longint'(px) - HALF_Q16;
            oy    = longint'(py) - HALF_Q16;
            // only the low 16 bits of the angle count: it wraps per turn
            frac  = ang[15:0];
            qbits = 2'((17'(frac) + 17'd8192) >> 14);
            quad  = quarter_t'(qbits);
            resid = frac - {qbits, 14'b0};
            z     = longint'($signed(resid)) * 65536;
            vx = (ox * longint'(GAIN_Q30) + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
            vy = (oy * longint'(GAIN_Q30) + (longint'(1) <<< (SCALE_SH - 1))) >>> SCALE_SH;
            case (quad)
                QTR_ONE:
                begin
                    tmp = vx;
                    vx  = -vy;
                    vy  = tmp;
                end
                QTR_TWO:
                begin
                    vx = -vx;
                    vy = -vy;
                end
                QTR_THREE:
                begin
                    tmp = vx;
                    vx  = vy;
                    vy  = -tmp;
                end
                default:
                begin
                end
            endcase
            for (int i = 0; i < CORDIC_N; i++)
            begin
                xs = vx >>> i;
                ys = vy >>> i;
                if (z >= 0)
                begin
                    vx = vx - ys;
                    vy = vy + xs;
                    z  = z - longint'(ATAN_TURNS[i]);
                end
                else
                begin
                    vx = vx + ys;
                    vy = vy - xs;
                    z  = z + longint'(ATAN_TURNS[i]);
                end
            end
            res.rx = fold_output(vx);
            res.ry = fold_output(vy);
            return res;
        endfunction

        function void note_point(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py,
                                 logic signed [ANGLE_W-1:0] ang);
            due_q.push_back(rotate_point(px, py, ang));
        endfunction

        function void check_result(logic signed [RES_W-1:0] rx, logic signed [RES_W-1:0] ry);
            rot_point_t want;
            if (due_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("unexpected word: x=%0d y=%0d", rx, ry);
                end
                return;
            end
            want = due_q.pop_front();
            if (rx !== want.rx || ry !== want.ry)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                begin
                    $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                             want.rx, want.ry, rx, ry);
                end
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function bit clean();
            return (mismatches == 0) && (due_q.size() == 0);
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    tb_phase_t    run_phase;
    int           cycle_count = 0;
    point_tracker tracker;

    prc_in_if  in_ch();
    prc_out_if out_ch();

    point_rotate_about_center u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pt_in  (in_ch),
        .pt_out (out_ch)
    );

    // clock
    always #10 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[point_rotate_about_center] ERROR");
            $finish;
        end
    end

    // note accepted inputs, check accepted outputs
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                tracker.note_point(in_ch.point_x, in_ch.point_y, in_ch.turn_angle);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                tracker.check_result(out_ch.rotated_x, out_ch.rotated_y);
            end
        end
    end

    // receiver: random stall bursts, one long hold-off, always ready at the end
    initial
    begin
        int  span_left;
        bit  hold_done;
        span_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (run_phase == PH_BACKPRESSURE && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                span_left = LONG_HOLD - 1;
                hold_done = 1'b1;
            end
            else if (run_phase == PH_STEADY)
            begin
                out_ch.ready <= 1'b1;
            end
            else if (span_left != 0)
            begin
                span_left--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                span_left = $urandom_range(0, 6);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                span_left = $urandom_range(0, 15);
            end
            @(posedge clk);
        end
    end

    // offer one word, optionally after an idle burst, and wait for acceptance
    task automatic offer_point(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                               input logic signed [ANGLE_W-1:0] ang, input int gap_odds);
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.point_x    <= px;
        in_ch.point_y    <= py;
        in_ch.turn_angle <= ang;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold the input idle until every predicted point has come out
    task automatic drain_points();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // corners, the centre, mid values and now and then beyond 1.0
    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return COORD_W'(65536);
            2:       return COORD_W'(32768);
            3:       return COORD_W'($urandom_range(65537, 131071));
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // eighth-turn boundaries, near misses, wrapped angles and plain random
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 15))
            0:       return ANGLE_W'($urandom_range(0, 16) * 8192 - 65536);
            1:       return ANGLE_W'($urandom_range(0, 16) * 8192 - 65537 + $urandom_range(0, 2));
            2:       return ANGLE_W'($urandom_range(0, 262143));
            default: return ANGLE_W'($urandom_range(0, 131072) - 65536);
        endcase
    endfunction

    // stimulus
    initial
    begin
        int gap_odds;
        tracker = new();
        rst_n            <= 1'b0;
        run_phase        <= PH_MIXED;
        in_ch.valid      <= 1'b0;
        in_ch.point_x    <= '0;
        in_ch.point_y    <= '0;
        in_ch.turn_angle <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // centre, corners and quarter, half and whole turns
        offer_point(17'd32768, 17'd32768, 18'sd0, 3);
        offer_point(17'd0, 17'd0, 18'sd0, 3);
        offer_point(17'd65536, 17'd65536, 18'sd0, 3);
        offer_point(17'd0, 17'd65536, 18'sd16384, 3);
        offer_point(17'd65536, 17'd0, -18'sd16384, 3);
        offer_point(17'd0, 17'd0, 18'sd32768, 3);
        offer_point(17'd65536, 17'd0, -18'sd32768, 3);
        offer_point(17'd0, 17'd0, 18'sd65536, 3);
        offer_point(17'd65536, 17'd65536, -18'sd65536, 3);
        offer_point(17'd65535, 17'd1, 18'sd100, 3);
        // quarter selection boundaries
        offer_point(17'd65536, 17'd32768, 18'sd8191, 3);
        offer_point(17'd65536, 17'd32768, 18'sd8192, 3);
        offer_point(17'd0, 17'd65536, 18'sd24575, 3);
        offer_point(17'd0, 17'd65536, 18'sd24576, 3);
        offer_point(17'd12345, 17'd54321, 18'sd40960, 3);
        offer_point(17'd54321, 17'd12345, 18'sd57344, 3);
        offer_point(17'd65536, 17'd0, -18'sd8192, 3);
        offer_point(17'd65536, 17'd0, -18'sd8193, 3);
        // angle beyond one turn wraps
        offer_point(17'd40000, 17'd20000, 18'sd131071, 3);
        offer_point(17'd40000, 17'd20000, -18'sd131072, 3);
        offer_point(17'd1000, 17'd60000, 18'sd73728, 3);
        // coordinates above 1.0, and saturation at the top of the range
        offer_point(17'd131071, 17'd0, 18'sd1000, 3);
        offer_point(17'd98304, 17'd131071, 18'sd8192, 3);
        offer_point(17'd131071, 17'd131071, 18'sd8192, 3);

        // random points, idling odds change every few dozen words
        gap_odds = 4;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       gap_odds = 0;
                    1:       gap_odds = 3;
                    default: gap_odds = 6;
                endcase
            end
            offer_point(pick_coord(), pick_coord(), pick_angle(), gap_odds);
        end

        // receiver holds off while words keep coming
        run_phase <= PH_BACKPRESSURE;
        for (int n = 0; n < HOLD_ITEMS; n++)
        begin
            offer_point(pick_coord(), pick_coord(), pick_angle(), 0);
        end
        drain_points();

        // last part: no idling on either side
        run_phase <= PH_STEADY;
        for (int n = 0; n < STEADY_ITEMS; n++)
        begin
            offer_point(pick_coord(), pick_coord(), pick_angle(), 0);
        end

        drain_points();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.clean())
        begin
            $display("[point_rotate_about_center] OK");
        end
        else
        begin
            $display("[point_rotate_about_center] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/prc_pkg.sv
rtl/core/prc_in_if.sv
rtl/core/prc_out_if.sv
rtl/core/prc_prescale.sv
rtl/core/prc_cordic.sv
rtl/core/point_rotate_about_center.sv
test/point_rotate_about_center_tb.sv
